### sv/peak_meter_led_bar_core_defines.svh
// Assertion macros for the peak meter core.
// Define ASSERT_OFF to compile the checks out.
`ifndef PEAK_METER_LED_BAR_CORE_DEFINES_SVH
`define PEAK_METER_LED_BAR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define PMLB_ASSERT(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define PMLB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PMLB_ASSERT(lbl, clk, rst_n, expr, msg)
`define PMLB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/pmlb_pkg.sv
// Types and constants of the peak meter core.
// No dependencies.
package pmlb_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 20;
    localparam int NUM_LEDS    = 12;
    localparam int HOLD_BITS   = 6;
    localparam int ADDR_BITS   = 3;
    localparam int DATA_BITS   = 32;

    localparam logic [HOLD_BITS-1:0]   HOLD_RESET = HOLD_BITS'(20);
    localparam logic [SAMPLE_BITS-1:0] ONE_LEVEL  = SAMPLE_BITS'(1) << FRAC_BITS;

    // ceil(2^20 * 10^(dB/20)) for -39 dB up to -6 dB; entry 0 at the LSB
    localparam logic [NUM_LEDS-1:0][SAMPLE_BITS-1:0] LED_THRESHOLD = {
        24'd525533, 24'd372049, 24'd263391, 24'd186467,
        24'd132008, 24'd93455,  24'd66161,  24'd46839,
        24'd33159,  24'd23475,  24'd16619,  24'd11766
    };

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_TICK   = 1'b1
    } t_kind;

    typedef enum logic {
        REG_HOLD_LIMIT = 1'b0
    } t_reg_index;

    typedef struct packed {
        t_kind                          kind;
        logic signed [SAMPLE_BITS-1:0]  sample;
        logic                           block_end;
        logic                           audio_running;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] peak_level;
        logic [NUM_LEDS-1:0]    led_bar;
        logic                   over_led;
    } t_out_item;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] peak;
        logic                   over_led;
    } t_meter_result;

endpackage

### sv/pmlb_stream_if.sv
// Valid/ready stream channel carrying one request payload.
// Payload type is set per instance.
interface pmlb_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### sv/pmlb_apb_regs.sv
// APB configuration register file: the overload hold limit.
// Depends on pmlb_pkg.
module pmlb_apb_regs
    import pmlb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output logic [HOLD_BITS-1:0] o_hold_limit
);
    logic [HOLD_BITS-1:0] r_hold_limit;
    logic                 w_hit;

    assign pready = 1'b1;
    assign w_hit  = (t_reg_index'(paddr[ADDR_BITS-1]) == REG_HOLD_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_limit <= HOLD_RESET;
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_hold_limit <= pwdata[HOLD_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_hit) begin
            prdata = DATA_BITS'(r_hold_limit);
        end
    end

    assign o_hold_limit = r_hold_limit;
endmodule

### sv/pmlb_meter_core.sv
// Meter state: running maximum, block peak and overload hold counter.
// Depends on pmlb_pkg.
module pmlb_meter_core
    import pmlb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  t_in_item             i_item,
    input  logic [HOLD_BITS-1:0] i_hold_limit,
    output t_meter_result        o_result
);
    logic [SAMPLE_BITS-1:0] r_running_max, n_running_max;
    logic [SAMPLE_BITS-1:0] r_block_peak,  n_block_peak;
    logic [HOLD_BITS-1:0]   r_over_count,  n_over_count;
    logic                   r_in_block,    n_in_block;
    logic [SAMPLE_BITS-1:0] w_mag;
    logic [SAMPLE_BITS-1:0] w_max;
    logic [HOLD_BITS-1:0]   w_count;

    assign w_mag = i_item.sample[SAMPLE_BITS-1] ? (~i_item.sample + 1'b1) : i_item.sample;
    assign w_max = (!r_in_block || (w_mag > r_running_max)) ? w_mag : r_running_max;

    always_comb begin
        w_count = r_over_count;
        if (r_block_peak >= ONE_LEVEL) begin
            w_count = HOLD_BITS'(1);
        end else if (r_over_count != '0) begin
            w_count = r_over_count + 1'b1;
        end
        if (w_count >= i_hold_limit) begin
            w_count = '0;
        end
    end

    always_comb begin
        n_running_max = r_running_max;
        n_block_peak  = r_block_peak;
        n_over_count  = r_over_count;
        n_in_block    = r_in_block;
        if (i_advance) begin
            case (i_item.kind)
                KIND_SAMPLE: begin
                    n_running_max = w_max;
                    n_in_block    = !i_item.block_end;
                    if (i_item.block_end) begin
                        n_block_peak = w_max;
                    end
                end
                KIND_TICK: begin
                    if (i_item.audio_running) begin
                        n_over_count = w_count;
                    end
                end
                default: begin
                    n_in_block = r_in_block;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_max <= '0;
            r_block_peak  <= '0;
            r_over_count  <= '0;
            r_in_block    <= 1'b0;
        end else begin
            r_running_max <= n_running_max;
            r_block_peak  <= n_block_peak;
            r_over_count  <= n_over_count;
            r_in_block    <= n_in_block;
        end
    end

    assign o_result.peak     = r_block_peak;
    assign o_result.over_led = (w_count != '0);
endmodule

### sv/pmlb_bar_enc.sv
// LED bar encoder: compares the peak against the segment thresholds.
// Depends on pmlb_pkg.
module pmlb_bar_enc
    import pmlb_pkg::*;
(
    input  logic [SAMPLE_BITS-1:0] i_peak,
    output logic [NUM_LEDS-1:0]    o_bar
);
    always_comb begin
        for (int k = 0; k < NUM_LEDS; k++) begin
            o_bar[k] = (i_peak >= LED_THRESHOLD[k]);
        end
    end
endmodule

### sv/pmlb_out_reg.sv
// Result register driving the output stream.
// Depends on pmlb_pkg and pmlb_stream_if.
module pmlb_out_reg
    import pmlb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_out_item          i_item,
    output logic               o_free,
    pmlb_stream_if.source      o_out
);
    logic      r_valid;
    t_out_item r_item;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_out.valid   = r_valid;
    assign o_out.payload = r_item;
endmodule

### sv/peak_meter_led_bar_core.sv
// Audio peak meter with a 12-segment LED bar and an overload lamp.
//
// i_in takes requests of type t_in_item: samples (kind KIND_SAMPLE) feed the
// running maximum, a sample with block_end latches it as the block peak.
// Ticks (kind KIND_TICK) with audio_running set update the overload hold
// counter and produce one t_out_item on o_out; ticks with audio stopped and
// all samples produce nothing. The hold limit is written over APB at byte
// address 0 and reads back there.
// A request is captured in the input register and its result is registered
// in the result register that drives o_out. Throughput is one request per
// cycle unless o_out stalls, bounded by the meter update between registers.
// When o_out stalls the result register holds; samples and silent ticks keep
// flowing, and the next tick with a result waits in the input register and
// blocks i_in until the held result is taken.
// Synchronous reset clears the peak, running maximum and hold counter and
// sets the hold limit to 20.
`include "peak_meter_led_bar_core_defines.svh"
module peak_meter_led_bar_core
    import pmlb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pmlb_stream_if.sink          i_in,
    pmlb_stream_if.source        o_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);
    logic                 r_in_valid;
    t_in_item             r_in_item;
    logic [HOLD_BITS-1:0] w_hold_limit;
    logic                 w_has_result;
    logic                 w_out_free;
    logic                 w_advance;
    logic                 w_load;
    t_meter_result        w_result;
    logic [NUM_LEDS-1:0]  w_bar;
    t_out_item            w_out_item;

    pmlb_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_hold_limit (w_hold_limit)
    );

    assign w_has_result = (r_in_item.kind == KIND_TICK) && r_in_item.audio_running;
    assign w_advance    = r_in_valid && (!w_has_result || w_out_free);
    assign w_load       = w_advance && w_has_result;
    assign i_in.ready   = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_item <= i_in.payload;
        end
    end

    pmlb_meter_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_advance),
        .i_item       (r_in_item),
        .i_hold_limit (w_hold_limit),
        .o_result     (w_result)
    );

    pmlb_bar_enc u_bar (
        .i_peak (w_result.peak),
        .o_bar  (w_bar)
    );

    assign w_out_item.peak_level = w_result.peak;
    assign w_out_item.led_bar    = w_bar;
    assign w_out_item.over_led   = w_result.over_led;

    pmlb_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_item  (w_out_item),
        .o_free  (w_out_free),
        .o_out   (o_out)
    );

    `PMLB_ASSERT(a_silent_never_stalls, i_clk, i_rst_n, !r_in_valid || w_has_result || w_advance, "request without result stalled")
    `PMLB_ASSERT(a_load_when_free, i_clk, i_rst_n, !w_load || w_out_free, "result register overwritten")
    `PMLB_ASSERT_NEXT(a_lamp_needs_limit, i_clk, i_rst_n, w_load && (w_hold_limit <= HOLD_BITS'(1)), !o_out.payload.over_led, "overload lamp lit with hold limit below two")
endmodule
